FILE: hdl/rsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
`default_nettype none

package rsc_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH_OUT_W = 8;
    localparam int DIV_STEPS   = 48;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        CMD_PUSH    = 4'd0,
        CMD_ADD     = 4'd1,
        CMD_SUB     = 4'd2,
        CMD_MUL     = 4'd3,
        CMD_DIV     = 4'd4,
        CMD_REM     = 4'd5,
        CMD_POPSHOW = 4'd6,
        CMD_TOP     = 4'd7,
        CMD_DUP     = 4'd8,
        CMD_SWAP    = 4'd9,
        CMD_CLEAR   = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FULL       = 3'd2,
        ST_ZERO_DIV   = 3'd3,
        ST_SWAP_SHORT = 3'd4,
        ST_UNKNOWN    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_REM
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } t_alu_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_B,
        S_TAKE_B,
        S_CHK_B,
        S_POP_A,
        S_TAKE_A,
        S_ALU_GO,
        S_ALU_WAIT,
        S_PUSH,
        S_SWAP_RD,
        S_SWAP_HOLD,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_FINISH
    } t_seq_state;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: hdl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: token sequencer, operand stack memory and result register.
//
// The input channel takes one token word (i_command, i_operand) when i_valid is high and
// o_stall is low. Each token yields exactly one result word (o_value, o_value_valid,
// o_status, o_stack_depth) on the output channel, taken when o_valid is high and i_stall
// is low.
// One token is worked on at a time, and o_stall stays high from the accepting edge until
// its result word is loaded into the output register. Clear, unknown commands and a short
// swap go straight to the result; push writes the operand; popshow pops and shows the top
// entry and top shows it; dup pushes a copy of it; swap reads and rewrites the two top
// entries; the arithmetic commands pop two operands, run the shared ALU and push. Divide and
// remainder use its divider, which retires one quotient bit per cycle over 48 bits; a zero
// divisor ends the token before the second pop. A pop from an empty stack skips its memory
// read. The next token can be taken in the cycle after the load. The stack is a single memory
// with one write and one registered read per cycle, so each stack access has its own state.
// The output register holds a finished word while the receiver stalls; the next token is
// accepted meanwhile, but its result waits until the held word has been taken.
// Synchronous reset empties the stack and drops any held result. The stack contents are
// not cleared; entries above the stack pointer are never used.
`default_nettype none

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [3:0]                     i_command,
    input  wire logic signed [31:0]             i_operand,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [31:0]                  o_value,
    output logic                                o_value_valid,
    output logic [2:0]                          o_status,
    output logic [rsc_pkg::DEPTH_OUT_W-1:0]     o_stack_depth
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);

    rsc_pkg::t_seq_state r_state, n_state;
    logic [3:0]          r_cmd, n_cmd;
    logic [31:0]         r_opnd, n_opnd;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic [31:0]         r_a, n_a;
    logic [31:0]         r_b, n_b;
    logic [31:0]         r_res, n_res;
    rsc_pkg::t_status    r_err, n_err;

    logic                r_o_valid, n_o_valid;
    logic [31:0]         r_o_value, n_o_value;
    logic                r_o_vv, n_o_vv;
    logic [2:0]          r_o_status, n_o_status;
    logic [rsc_pkg::DEPTH_OUT_W-1:0] r_o_depth, n_o_depth;

    logic [31:0]         mem [STACK_DEPTH];
    logic [31:0]         r_mem_q;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [31:0]         mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic                sp_empty;

    rsc_pkg::t_alu_req   alu_req;
    rsc_pkg::t_alu_op    alu_op;
    logic                alu_done;
    logic [31:0]         alu_result;

    function automatic rsc_pkg::t_status note_err(rsc_pkg::t_status cur,
                                                  rsc_pkg::t_status code);
        return (cur == rsc_pkg::ST_OK) ? code : cur;
    endfunction

    rsc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsc_pkg::S_IDLE;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_opnd     <= n_opnd;
        r_a        <= n_a;
        r_b        <= n_b;
        r_res      <= n_res;
        r_err      <= n_err;
        r_o_value  <= n_o_value;
        r_o_vv     <= n_o_vv;
        r_o_status <= n_o_status;
        r_o_depth  <= n_o_depth;
    end

    always_comb begin
        unique case (rsc_pkg::t_cmd'(r_cmd))
            rsc_pkg::CMD_SUB: alu_op = rsc_pkg::ALU_SUB;
            rsc_pkg::CMD_MUL: alu_op = rsc_pkg::ALU_MUL;
            rsc_pkg::CMD_DIV: alu_op = rsc_pkg::ALU_DIV;
            rsc_pkg::CMD_REM: alu_op = rsc_pkg::ALU_REM;
            default:          alu_op = rsc_pkg::ALU_ADD;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_opnd     = r_opnd;
        n_sp       = r_sp;
        n_a        = r_a;
        n_b        = r_b;
        n_res      = r_res;
        n_err      = r_err;
        n_o_value  = r_o_value;
        n_o_vv     = r_o_vv;
        n_o_status = r_o_status;
        n_o_depth  = r_o_depth;
        n_o_valid  = r_o_valid && i_stall;
        sp_m1      = r_sp - 1'b1;
        sp_m2      = r_sp - SP_W'(2);
        sp_empty   = (r_sp == '0);
        mem_we     = 1'b0;
        mem_waddr  = r_sp[IDX_W-1:0];
        mem_wdata  = r_res;
        mem_raddr  = sp_m1[IDX_W-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = alu_op;

        unique case (r_state)
            rsc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_opnd  = i_operand;
                    n_err   = rsc_pkg::ST_OK;
                    n_state = rsc_pkg::S_DECODE;
                end
            end
            rsc_pkg::S_DECODE: begin
                case (rsc_pkg::t_cmd'(r_cmd)) inside
                    rsc_pkg::CMD_PUSH: begin
                        n_res   = r_opnd;
                        n_state = rsc_pkg::S_PUSH;
                    end
                    rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL, rsc_pkg::CMD_DIV,
                    rsc_pkg::CMD_REM, rsc_pkg::CMD_POPSHOW, rsc_pkg::CMD_TOP,
                    rsc_pkg::CMD_DUP: begin
                        n_state = rsc_pkg::S_POP_B;
                    end
                    rsc_pkg::CMD_SWAP: begin
                        if (r_sp > SP_W'(1)) begin
                            n_state = rsc_pkg::S_SWAP_RD;
                        end else begin
                            n_err   = note_err(r_err, rsc_pkg::ST_SWAP_SHORT);
                            n_state = rsc_pkg::S_FINISH;
                        end
                    end
                    rsc_pkg::CMD_CLEAR: begin
                        n_sp    = '0;
                        n_state = rsc_pkg::S_FINISH;
                    end
                    default: begin
                        n_err   = note_err(r_err, rsc_pkg::ST_UNKNOWN);
                        n_state = rsc_pkg::S_FINISH;
                    end
                endcase
            end
            rsc_pkg::S_POP_B: begin
                if (sp_empty) begin
                    n_err   = note_err(r_err, rsc_pkg::ST_EMPTY);
                    n_b     = '0;
                    n_state = rsc_pkg::S_CHK_B;
                end else begin
                    if (r_cmd != rsc_pkg::CMD_TOP && r_cmd != rsc_pkg::CMD_DUP) begin
                        n_sp = sp_m1;
                    end
                    n_state = rsc_pkg::S_TAKE_B;
                end
            end
            rsc_pkg::S_TAKE_B: begin
                n_b     = r_mem_q;
                n_state = rsc_pkg::S_CHK_B;
            end
            rsc_pkg::S_CHK_B: begin
                case (rsc_pkg::t_cmd'(r_cmd)) inside
                    rsc_pkg::CMD_DIV, rsc_pkg::CMD_REM: begin
                        if (r_b == '0) begin
                            n_err   = note_err(r_err, rsc_pkg::ST_ZERO_DIV);
                            n_state = rsc_pkg::S_FINISH;
                        end else begin
                            n_state = rsc_pkg::S_POP_A;
                        end
                    end
                    rsc_pkg::CMD_POPSHOW, rsc_pkg::CMD_TOP: begin
                        n_state = rsc_pkg::S_FINISH;
                    end
                    rsc_pkg::CMD_DUP: begin
                        n_res   = r_b;
                        n_state = rsc_pkg::S_PUSH;
                    end
                    default: begin
                        n_state = rsc_pkg::S_POP_A;
                    end
                endcase
            end
            rsc_pkg::S_POP_A: begin
                if (sp_empty) begin
                    n_err   = note_err(r_err, rsc_pkg::ST_EMPTY);
                    n_a     = '0;
                    n_state = rsc_pkg::S_ALU_GO;
                end else begin
                    n_sp    = sp_m1;
                    n_state = rsc_pkg::S_TAKE_A;
                end
            end
            rsc_pkg::S_TAKE_A: begin
                n_a     = r_mem_q;
                n_state = rsc_pkg::S_ALU_GO;
            end
            rsc_pkg::S_ALU_GO: begin
                alu_req.start = 1'b1;
                n_state       = rsc_pkg::S_ALU_WAIT;
            end
            rsc_pkg::S_ALU_WAIT: begin
                if (alu_done) begin
                    n_res   = alu_result;
                    n_state = rsc_pkg::S_PUSH;
                end
            end
            rsc_pkg::S_PUSH: begin
                if (r_sp < SP_W'(STACK_DEPTH)) begin
                    mem_we = 1'b1;
                    n_sp   = r_sp + 1'b1;
                end else begin
                    n_err = note_err(r_err, rsc_pkg::ST_FULL);
                end
                n_state = rsc_pkg::S_FINISH;
            end
            rsc_pkg::S_SWAP_RD: begin
                n_state = rsc_pkg::S_SWAP_HOLD;
            end
            rsc_pkg::S_SWAP_HOLD: begin
                n_b       = r_mem_q;
                mem_raddr = sp_m2[IDX_W-1:0];
                n_state   = rsc_pkg::S_SWAP_WR1;
            end
            rsc_pkg::S_SWAP_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = sp_m1[IDX_W-1:0];
                mem_wdata = r_mem_q;
                n_state   = rsc_pkg::S_SWAP_WR2;
            end
            rsc_pkg::S_SWAP_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = sp_m2[IDX_W-1:0];
                mem_wdata = r_b;
                n_state   = rsc_pkg::S_FINISH;
            end
            rsc_pkg::S_FINISH: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_vv     = (r_cmd == rsc_pkg::CMD_POPSHOW) || (r_cmd == rsc_pkg::CMD_TOP);
                    n_o_value  = n_o_vv ? r_b : 32'd0;
                    n_o_status = r_err;
                    n_o_depth  = rsc_pkg::DEPTH_OUT_W'(r_sp);
                    n_state    = rsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != rsc_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_value       = r_o_value;
    assign o_value_valid = r_o_vv;
    assign o_status      = r_o_status;
    assign o_stack_depth = r_o_depth;

endmodule

`default_nettype wire

FILE: hdl/rsc_alu.sv
// Shared arithmetic unit: saturating add, subtract, Q16.16 multiply, and a bit-serial divider.
`default_nettype none

module rsc_alu (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsc_pkg::t_alu_req             i_req,
    input  wire logic signed [rsc_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [rsc_pkg::DATA_W-1:0] i_b,
    output logic                               o_done,
    output logic [rsc_pkg::DATA_W-1:0]         o_result
);

    rsc_pkg::t_alu_state r_state, n_state;
    rsc_pkg::t_alu_op    r_op, n_op;
    logic [31:0]          r_res, n_res;
    logic signed [63:0]   r_prod, n_prod;
    logic [31:0]          r_rem, n_rem;
    logic [47:0]          r_quo, n_quo;
    logic [31:0]          r_dvs, n_dvs;
    logic                 r_sa, n_sa;
    logic                 r_sb, n_sb;
    logic [rsc_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [32:0] sum;
    logic [47:0] shifted;
    logic [33:0] diff;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsc_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op   <= n_op;
        r_res  <= n_res;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_res   = r_res;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        mag_a   = i_a[31] ? (~i_a + 32'd1) : i_a;
        mag_b   = i_b[31] ? (~i_b + 32'd1) : i_b;
        sum     = (i_req.op == rsc_pkg::ALU_SUB) ? ({i_a[31], i_a} - {i_b[31], i_b})
                                                 : ({i_a[31], i_a} + {i_b[31], i_b});
        shifted = r_prod[63:16];
        diff    = {1'b0, r_rem, r_quo[47]} - {2'b00, r_dvs};

        unique case (r_state)
            rsc_pkg::A_IDLE: begin
                if (i_req.start) begin
                    n_op = i_req.op;
                    unique case (i_req.op)
                        rsc_pkg::ALU_ADD, rsc_pkg::ALU_SUB: begin
                            if (sum[32] != sum[31]) begin
                                n_res = sum[32] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
                            end else begin
                                n_res = sum[31:0];
                            end
                            n_state = rsc_pkg::A_DONE;
                        end
                        rsc_pkg::ALU_MUL: begin
                            n_prod  = i_a * i_b;
                            n_state = rsc_pkg::A_MUL;
                        end
                        default: begin
                            n_sa    = i_a[31];
                            n_sb    = i_b[31];
                            n_dvs   = mag_b;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_quo   = (i_req.op == rsc_pkg::ALU_DIV) ? {mag_a, 16'd0}
                                                                     : {16'd0, mag_a};
                            n_state = rsc_pkg::A_DIV;
                        end
                    endcase
                end
            end
            rsc_pkg::A_MUL: begin
                if (shifted[47:31] == {17{shifted[47]}}) begin
                    n_res = shifted[31:0];
                end else begin
                    n_res = shifted[47] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
                end
                n_state = rsc_pkg::A_DONE;
            end
            rsc_pkg::A_DIV: begin
                if (!diff[33]) begin
                    n_rem = diff[31:0];
                    n_quo = {r_quo[46:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_quo[47]};
                    n_quo = {r_quo[46:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
                    n_state = rsc_pkg::A_FIX;
                end
            end
            rsc_pkg::A_FIX: begin
                if (r_op == rsc_pkg::ALU_REM) begin
                    n_res = r_sa ? (~r_rem + 32'd1) : r_rem;
                end else if (r_sa ^ r_sb) begin
                    if ((r_quo[47:32] != 16'd0) || (r_quo[31] && (r_quo[30:0] != 31'd0))) begin
                        n_res = rsc_pkg::Q_MIN;
                    end else begin
                        n_res = ~r_quo[31:0] + 32'd1;
                    end
                end else begin
                    if (r_quo[47:31] != 17'd0) begin
                        n_res = rsc_pkg::Q_MAX;
                    end else begin
                        n_res = r_quo[31:0];
                    end
                end
                n_state = rsc_pkg::A_DONE;
            end
            rsc_pkg::A_DONE: begin
                o_done  = 1'b1;
                n_state = rsc_pkg::A_IDLE;
            end
            default: begin
                n_state = rsc_pkg::A_IDLE;
            end
        endcase
    end

    assign o_result = r_res;

endmodule

`default_nettype wire
